[src/spro_pkg.sv]
// shared types, constants and pixel combine functions for the serpentine raster op block
package spro_pkg;

   localparam int COLUMNS   = 16;
   localparam int ROWS      = 16;
   localparam int PIXELS    = COLUMNS * ROWS;
   localparam int PIX_W     = (PIXELS > 1) ? $clog2(PIXELS) : 1;
   localparam int IDX_W     = 18;
   localparam int QDEPTH    = 2;
   localparam int QPTR_W    = 1;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;

   localparam logic signed [IDX_W-1:0] ROWS_S    = IDX_W'(ROWS);
   localparam logic signed [IDX_W-1:0] ROWS_M1_S = IDX_W'(ROWS - 1);
   localparam logic signed [IDX_W-1:0] PIXELS_S  = IDX_W'(PIXELS);

   typedef enum logic [1:0] {
      OVL_REPLACE = 2'd0,
      OVL_OR      = 2'd1,
      OVL_ANDNOT  = 2'd2,
      OVL_XOR     = 2'd3
   } ovl_mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE  = 2'd0,
      CSR_RED   = 2'd1,
      CSR_GREEN = 2'd2,
      CSR_BLUE  = 2'd3
   } csr_index_type;

   typedef enum logic {
      OP_DRAW  = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef enum logic {
      BK_IDLE,
      BK_EXEC
   } bk_state_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } px_type;

   typedef struct packed {
      ovl_mode_type mode;
      px_type       color;
   } cfg_type;

   typedef struct packed {
      logic             flush;
      logic             in_range;
      logic [PIX_W-1:0] addr;
      logic [7:0]       index;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      logic       in_range;
      logic [7:0] index;
      px_type     px;
      logic       changed;
      logic       frame_due;
   } rsp_type;

   function automatic logic [7:0] combine_chan(logic [7:0] old_v, logic [7:0] color,
                                               ovl_mode_type mode);
      logic [7:0] res;
      unique case (mode)
         OVL_REPLACE: res = color;
         OVL_OR:      res = old_v | color;
         OVL_ANDNOT:  res = old_v & ~color;
         OVL_XOR:     res = old_v ^ color;
         default:     res = color;
      endcase
      return res;
   endfunction

   function automatic px_type combine_px(px_type old_px, cfg_type cfg);
      px_type res;
      res.red   = combine_chan(old_px.red, cfg.color.red, cfg.mode);
      res.green = combine_chan(old_px.green, cfg.color.green, cfg.mode);
      res.blue  = combine_chan(old_px.blue, cfg.color.blue, cfg.mode);
      return res;
   endfunction

endpackage

[src/spro_front.sv]
// front end: request acceptance and serpentine index classification
module spro_front (
   input  logic                start,
   input  logic                req_op,
   input  logic signed [7:0]   req_column,
   input  logic signed [7:0]   req_row,
   input  logic                q_full,
   output logic                push,
   output spro_pkg::q_item_type push_item
);
   import spro_pkg::*;

   logic signed [IDX_W-1:0] col_ext;
   logic signed [IDX_W-1:0] row_ext;
   logic signed [IDX_W-1:0] row_off;
   logic signed [IDX_W-1:0] idx;

   assign col_ext = IDX_W'(req_column);
   assign row_ext = IDX_W'(req_row);

   // odd columns run bottom to top
   assign row_off = req_column[0] ? (ROWS_M1_S - row_ext) : row_ext;
   assign idx     = (col_ext * ROWS_S) + row_off;

   assign push = start && !q_full;

   always_comb begin
      push_item.flush    = (op_type'(req_op) == OP_FLUSH);
      push_item.in_range = !idx[IDX_W-1] && (idx < PIXELS_S);
      push_item.addr     = idx[PIX_W-1:0];
      push_item.index    = idx[7:0];
   end

endmodule

[src/spro_queue.sv]
// two-entry request queue between front and back
module spro_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  spro_pkg::q_item_type push_item,
   input  logic                 pop,
   output spro_pkg::q_item_type head_item,
   output logic                 empty,
   output logic                 full
);
   import spro_pkg::*;

   q_item_type          entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W:0]     cnt_ff;
   logic [QPTR_W:0]     cnt_in;

   assign empty     = (cnt_ff == '0);
   assign full      = (cnt_ff == (QPTR_W+1)'(QDEPTH));
   assign head_item = entry_ff[rd_ptr_ff];

   always_comb begin
      cnt_in = cnt_ff;
      case ({push, pop})
         2'b10:   cnt_in = cnt_ff + 1'b1;
         2'b01:   cnt_in = cnt_ff - 1'b1;
         default: cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

[src/spro_back.sv]
// back end: frame store read-modify-write, dirty flag and response register
module spro_back (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 q_empty,
   input  spro_pkg::q_item_type q_head,
   input  spro_pkg::cfg_type    cfg,
   output logic                 pop,
   output spro_pkg::rsp_type    rsp
);
   import spro_pkg::*;

   px_type             mem [PIXELS];
   logic [PIXELS-1:0]  valid_ff;
   px_type             rd_data_ff;
   logic               rd_vld_ff;
   bk_state_type       state_ff;
   bk_state_type       state_in;
   q_item_type         item_ff;
   q_item_type         item_in;
   logic               dirty_ff;
   logic               dirty_in;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic               rd_en;
   logic               wr_en;
   px_type             old_px;
   px_type             new_px;
   logic               changed;

   // entries never written read as black
   assign old_px  = rd_vld_ff ? rd_data_ff : '0;
   assign new_px  = combine_px(old_px, cfg);
   assign changed = (new_px != old_px);
   assign rsp     = rsp_ff;

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      dirty_in = dirty_ff;
      rsp_in   = '0;
      pop      = 1'b0;
      rd_en    = 1'b0;
      wr_en    = 1'b0;
      unique case (state_ff)
         BK_IDLE: begin
            if (!q_empty) begin
               pop      = 1'b1;
               rd_en    = 1'b1;
               item_in  = q_head;
               state_in = BK_EXEC;
            end
         end
         BK_EXEC: begin
            rsp_in.valid = 1'b1;
            state_in     = BK_IDLE;
            if (item_ff.flush) begin
               rsp_in.frame_due = dirty_ff;
               dirty_in         = 1'b0;
            end else if (item_ff.in_range) begin
               wr_en           = 1'b1;
               rsp_in.in_range = 1'b1;
               rsp_in.index    = item_ff.index;
               rsp_in.px       = new_px;
               rsp_in.changed  = changed;
               if (changed) begin
                  dirty_in = 1'b1;
               end
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         dirty_ff <= 1'b0;
         valid_ff <= '0;
         rsp_ff   <= '0;
      end else begin
         state_ff <= state_in;
         dirty_ff <= dirty_in;
         rsp_ff   <= rsp_in;
         if (wr_en) begin
            valid_ff[item_ff.addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (rd_en) begin
         rd_vld_ff <= valid_ff[q_head.addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[item_ff.addr] <= new_px;
      end
      if (rd_en) begin
         rd_data_ff <= mem[q_head.addr];
      end
   end

endmodule

[src/serpentine_pixel_raster_op.sv]
// top level of the serpentine matrix frame store and raster operation block
//
//  channel   direction  handshake            payload
//  request   in         start / busy         req_op, req_column, req_row
//  response  out        rsp_valid strobe     rsp_in_range .. rsp_frame_due
//  csr       in         csr_we               csr_index, csr_wdata
//
// the back end finishes a request (frame store read, then combine and write) before it pops the next
// a response is registered once its request has passed the queue, the frame store read and the combine
// busy is high while the two-entry queue is full
// reset clears the valid bits of the frame store at once, no clearing pass
// responses are never held off by the receiver
module serpentine_pixel_raster_op (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic                              req_op,
   input  logic signed [7:0]                 req_column,
   input  logic signed [7:0]                 req_row,
   output logic                              rsp_valid,
   output logic                              rsp_in_range,
   output logic [7:0]                        rsp_pixel_index,
   output logic [7:0]                        rsp_new_red,
   output logic [7:0]                        rsp_new_green,
   output logic [7:0]                        rsp_new_blue,
   output logic                              rsp_pixel_changed,
   output logic                              rsp_frame_due,
   input  logic                              csr_we,
   input  logic [spro_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [spro_pkg::CSR_DAT_W-1:0]    csr_wdata
);
   import spro_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       push;
   q_item_type push_item;
   q_item_type head_item;
   logic       q_empty;
   logic       q_full;
   logic       pop;
   rsp_type    rsp;

   assign busy = q_full;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_MODE:  cfg_in.mode        = ovl_mode_type'(csr_wdata[1:0]);
            CSR_RED:   cfg_in.color.red   = csr_wdata[7:0];
            CSR_GREEN: cfg_in.color.green = csr_wdata[7:0];
            CSR_BLUE:  cfg_in.color.blue  = csr_wdata[7:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   spro_front u_front (
      .start      (start),
      .req_op     (req_op),
      .req_column (req_column),
      .req_row    (req_row),
      .q_full     (q_full),
      .push       (push),
      .push_item  (push_item)
   );

   spro_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .empty     (q_empty),
      .full      (q_full)
   );

   spro_back u_back (
      .clock   (clock),
      .reset   (reset),
      .q_empty (q_empty),
      .q_head  (head_item),
      .cfg     (cfg_ff),
      .pop     (pop),
      .rsp     (rsp)
   );

   assign rsp_valid         = rsp.valid;
   assign rsp_in_range      = rsp.in_range;
   assign rsp_pixel_index   = rsp.index;
   assign rsp_new_red       = rsp.px.red;
   assign rsp_new_green     = rsp.px.green;
   assign rsp_new_blue      = rsp.px.blue;
   assign rsp_pixel_changed = rsp.changed;
   assign rsp_frame_due     = rsp.frame_due;

`ifndef SYNTHESIS
   a_flush_only_due : assert property (@(posedge clock) disable iff (reset)
      rsp_frame_due |-> (rsp_valid && !rsp_in_range && !rsp_pixel_changed))
      else $error("frame_due on a draw response");

   a_change_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_pixel_changed |-> (rsp_valid && rsp_in_range))
      else $error("pixel change reported outside the store");

   a_spaced_rsp : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("responses on consecutive cycles");

   a_no_push_full : assert property (@(posedge clock) disable iff (reset)
      (q_full && !pop) |=> q_full)
      else $error("queue lost an entry while full");
`endif

endmodule

[tb/sv/tb.sv]
// testbench for the serpentine matrix frame store and raster operation block
`timescale 1ns / 1ps

module tb;
   import spro_pkg::*;

   localparam int CYCLE_LIMIT = 100000;

   typedef struct packed {
      logic       in_range;
      logic [7:0] index;
      px_type     px;
      logic       changed;
      logic       frame_due;
   } raster_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_op;
   logic signed [7:0]    req_column;
   logic signed [7:0]    req_row;
   logic                 rsp_valid;
   logic                 rsp_in_range;
   logic [7:0]           rsp_pixel_index;
   logic [7:0]           rsp_new_red;
   logic [7:0]           rsp_new_green;
   logic [7:0]           rsp_new_blue;
   logic                 rsp_pixel_changed;
   logic                 rsp_frame_due;
   logic                 csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   px_type            frame_model [PIXELS];
   logic              dirty_model;
   ovl_mode_type      mode_model;
   px_type            color_model;
   raster_result_type pending_results [$];
   int                mismatches;
   int                cycles;
   int                idle_pct;

   serpentine_pixel_raster_op uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_op            (req_op),
      .req_column        (req_column),
      .req_row           (req_row),
      .rsp_valid         (rsp_valid),
      .rsp_in_range      (rsp_in_range),
      .rsp_pixel_index   (rsp_pixel_index),
      .rsp_new_red       (rsp_new_red),
      .rsp_new_green     (rsp_new_green),
      .rsp_new_blue      (rsp_new_blue),
      .rsp_pixel_changed (rsp_pixel_changed),
      .rsp_frame_due     (rsp_frame_due),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   initial begin
      clock = 1'b0;
   end

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: errors");
         $finish;
      end
   end

   function automatic logic [7:0] blend_channel(logic [7:0] old_v, logic [7:0] color);
      logic [7:0] res;
      case (mode_model)
         OVL_REPLACE: res = color;
         OVL_OR:      res = old_v | color;
         OVL_ANDNOT:  res = old_v & ~color;
         default:     res = old_v ^ color;
      endcase
      return res;
   endfunction

   function automatic raster_result_type apply_raster_op(op_type op, logic signed [7:0] col,
                                                         logic signed [7:0] row);
      raster_result_type res;
      int                lin;
      px_type            old_px;
      px_type            new_px;
      res = '0;
      if (op == OP_FLUSH) begin
         res.frame_due = dirty_model;
         dirty_model = 1'b0;
         return res;
      end
      if (col[0]) begin
         lin = int'(col) * ROWS + ROWS - 1 - int'(row);
      end else begin
         lin = int'(col) * ROWS + int'(row);
      end
      if (lin < 0 || lin >= PIXELS) begin
         return res;
      end
      old_px = frame_model[lin];
      new_px.red   = blend_channel(old_px.red, color_model.red);
      new_px.green = blend_channel(old_px.green, color_model.green);
      new_px.blue  = blend_channel(old_px.blue, color_model.blue);
      frame_model[lin] = new_px;
      res.in_range = 1'b1;
      res.index    = lin[7:0];
      res.px       = new_px;
      if (new_px != old_px) begin
         res.changed = 1'b1;
         dirty_model = 1'b1;
      end
      return res;
   endfunction

   task automatic compare_field(string name, int exp_v, int act_v);
      if (exp_v != act_v) begin
         $display("%0t %s expected %0h actual %0h", $time, name, exp_v, act_v);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : response_check
      raster_result_type exp_r;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            $display("%0t response expected none actual index %0h", $time, rsp_pixel_index);
            mismatches++;
         end else begin
            exp_r = pending_results.pop_front();
            compare_field("in_range", exp_r.in_range, rsp_in_range);
            compare_field("pixel_index", exp_r.index, rsp_pixel_index);
            compare_field("new_red", exp_r.px.red, rsp_new_red);
            compare_field("new_green", exp_r.px.green, rsp_new_green);
            compare_field("new_blue", exp_r.px.blue, rsp_new_blue);
            compare_field("pixel_changed", exp_r.changed, rsp_pixel_changed);
            compare_field("frame_due", exp_r.frame_due, rsp_frame_due);
         end
      end
   end

   task automatic send_request(op_type op, logic [7:0] col, logic [7:0] row);
      start      <= 1'b1;
      req_op     <= op;
      req_column <= col;
      req_row    <= row;
      do @(posedge clock); while (busy);
      pending_results.push_back(apply_raster_op(op, col, row));
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic random_request();
      op_type     op;
      logic [7:0] col;
      logic [7:0] row;
      op = ($urandom_range(0, 99) < 10) ? OP_FLUSH : OP_DRAW;
      if ($urandom_range(0, 99) < 80) begin
         col = 8'($urandom_range(0, COLUMNS - 1));
         row = 8'($urandom_range(0, ROWS - 1));
      end else begin
         col = 8'($urandom);
         row = 8'($urandom);
      end
      send_request(op, col, row);
   endtask

   task automatic drain_block();
      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic put_register(csr_index_type idx, logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         CSR_MODE:  mode_model = ovl_mode_type'(value[1:0]);
         CSR_RED:   color_model.red = value;
         CSR_GREEN: color_model.green = value;
         default:   color_model.blue = value;
      endcase
   endtask

   task automatic write_config(ovl_mode_type mode, logic [7:0] red, logic [7:0] green,
                               logic [7:0] blue);
      drain_block();
      put_register(CSR_MODE, 8'(mode));
      put_register(CSR_RED, red);
      put_register(CSR_GREEN, green);
      put_register(CSR_BLUE, blue);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic test_reset_state();
      idle_pct = 0;
      send_request(OP_DRAW, 8'd0, 8'd0);
      send_request(OP_FLUSH, 8'd0, 8'd0);
      drain_block();
   endtask

   task automatic test_serpentine_corners();
      write_config(OVL_REPLACE, 8'hff, 8'h00, 8'h80);
      send_request(OP_DRAW, 8'd0, 8'd0);
      send_request(OP_DRAW, 8'd0, 8'd0);
      send_request(OP_DRAW, 8'd1, 8'd0);
      send_request(OP_DRAW, 8'd1, 8'd15);
      send_request(OP_DRAW, 8'd15, 8'd15);
      send_request(OP_DRAW, 8'd15, 8'd0);
      send_request(OP_DRAW, 8'd14, 8'd15);
      send_request(OP_DRAW, -8'sd1, -8'sd5);
      send_request(OP_DRAW, 8'd16, -8'sd1);
      send_request(OP_FLUSH, 8'h5a, 8'ha5);
      send_request(OP_FLUSH, 8'hff, 8'h80);
      send_request(OP_DRAW, 8'h80, 8'h80);
      send_request(OP_DRAW, 8'sd127, 8'sd127);
      send_request(OP_DRAW, 8'h80, 8'sd127);
      send_request(OP_DRAW, 8'sd127, 8'h80);
      send_request(OP_DRAW, 8'd0, -8'sd1);
      send_request(OP_DRAW, 8'd16, 8'd0);
      send_request(OP_FLUSH, 8'd0, 8'd0);
      drain_block();
   endtask

   task automatic test_overlay_modes();
      int idle_phases [3];
      idle_phases = '{0, 48, 7};
      for (int m = 0; m < 4; m++) begin
         for (int p = 0; p < 3; p++) begin
            if (p == 0) begin
               write_config(ovl_mode_type'(m), 8'hff, 8'h00, 8'hff);
            end else begin
               write_config(ovl_mode_type'(m), 8'($urandom), 8'($urandom), 8'($urandom));
            end
            idle_pct = idle_phases[p];
            repeat (100) random_request();
         end
      end
      drain_block();
   endtask

   task automatic test_mixed_settings();
      for (int k = 0; k < 5; k++) begin
         write_config(ovl_mode_type'($urandom_range(0, 3)), 8'($urandom), 8'($urandom),
                      8'($urandom));
         idle_pct = (k % 3 == 0) ? 0 : ((k % 3 == 1) ? 48 : 7);
         repeat (100) random_request();
      end
      drain_block();
   endtask

   initial begin
      reset       <= 1'b1;
      start       <= 1'b0;
      req_op      <= OP_DRAW;
      req_column  <= '0;
      req_row     <= '0;
      csr_we      <= 1'b0;
      csr_index   <= CSR_MODE;
      csr_wdata   <= '0;
      mismatches  = 0;
      idle_pct    = 0;
      dirty_model = 1'b0;
      mode_model  = OVL_REPLACE;
      color_model = '0;
      for (int i = 0; i < PIXELS; i++) frame_model[i] = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_serpentine_corners();
      test_overlay_modes();
      test_mixed_settings();
      write_config(OVL_XOR, 8'hff, 8'hff, 8'hff);
      idle_pct = 0;
      repeat (60) random_request();
      drain_block();
      if (mismatches == 0) begin
         $display("tb: clean");
      end else begin
         $display("tb: errors");
      end
      $finish;
   end

endmodule
